@@ rtl/core/assert_macros.svh @@
// Assertion helpers used by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is held.
`define ASSERT_IMPLY(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is held.
`define ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ rtl/core/q5kdp_pkg.sv @@
package q5kdp_pkg;

    localparam int SCALE_WORDS   = 3;
    localparam int SCALE_W       = 6;
    localparam int WEIGHT_W      = 5;
    localparam int ACT_W         = 8;
    localparam int SCW_W         = SCALE_W + WEIGHT_W;
    localparam int DOT_PROD_W    = SCW_W + 1 + ACT_W;
    localparam int CORR_PROD_W   = SCALE_W + 1 + ACT_W;
    localparam int DOT_ACC_W     = 27;
    localparam int CORR_ACC_W    = 23;
    localparam int MIN_CORR_W    = 22;
    localparam int S_TDATA_W     = 72;
    localparam int M_TDATA_W     = 56;

    typedef enum logic {
        ACT_SCALE = 1'b0,
        ACT_DATA  = 1'b1
    } t_action;

    typedef struct packed {
        logic valid;
        logic last;
    } t_ctrl;

    typedef struct packed {
        logic [SCALE_W-1:0] scale;
        logic [SCALE_W-1:0] min;
    } t_scale_min;

    function automatic t_scale_min unpack_scale_min(
        input logic [31:0] w0,
        input logic [31:0] w1,
        input logic [31:0] w2,
        input logic [2:0]  sub
    );
        t_scale_min res;
        logic [1:0] k;
        logic [7:0] b0;
        logic [7:0] b1;
        logic [7:0] b2;
        k  = sub[1:0];
        b0 = w0[k*8 +: 8];
        b1 = w1[k*8 +: 8];
        b2 = w2[k*8 +: 8];
        if (!sub[2]) begin
            res.scale = b0[5:0];
            res.min   = b1[5:0];
        end else begin
            res.scale = {b0[7:6], b2[3:0]};
            res.min   = {b1[7:6], b2[7:4]};
        end
        return res;
    endfunction

endpackage

@@ rtl/core/q5kdp_lane.sv @@
module q5kdp_lane (
    input  logic                                          i_clk,
    input  logic                                          i_en,
    input  logic        [q5kdp_pkg::SCALE_W-1:0]          i_scale,
    input  logic        [q5kdp_pkg::SCALE_W-1:0]          i_min,
    input  logic        [q5kdp_pkg::WEIGHT_W-1:0]         i_weight,
    input  logic signed [q5kdp_pkg::ACT_W-1:0]            i_act,
    output logic signed [q5kdp_pkg::DOT_PROD_W-1:0]       o_dot_prod,
    output logic signed [q5kdp_pkg::CORR_PROD_W-1:0]      o_corr_prod
);
    import q5kdp_pkg::*;

    logic        [SCW_W-1:0]       r_scw;
    logic        [SCALE_W-1:0]     r_min;
    logic signed [ACT_W-1:0]       r_act;
    logic        [SCW_W-1:0]       n_scw;
    logic signed [DOT_PROD_W-1:0]  r_dot_prod;
    logic signed [CORR_PROD_W-1:0] r_corr_prod;
    logic signed [DOT_PROD_W-1:0]  n_dot_prod;
    logic signed [CORR_PROD_W-1:0] n_corr_prod;

    assign n_scw       = SCW_W'(i_scale) * SCW_W'(i_weight);
    assign n_dot_prod  = $signed({1'b0, r_scw}) * r_act;
    assign n_corr_prod = $signed({1'b0, r_min}) * r_act;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_scw       <= n_scw;
            r_min       <= i_min;
            r_act       <= i_act;
            r_dot_prod  <= n_dot_prod;
            r_corr_prod <= n_corr_prod;
        end
    end

    assign o_dot_prod  = r_dot_prod;
    assign o_corr_prod = r_corr_prod;

endmodule

@@ rtl/core/q5kdp_merge.sv @@
module q5kdp_merge (
    input  logic                                          i_clk,
    input  logic                                          i_rst_n,
    input  logic                                          i_en,
    input  q5kdp_pkg::t_ctrl                              i_ctrl,
    input  logic signed [q5kdp_pkg::DOT_PROD_W-1:0]       i_dot_lo,
    input  logic signed [q5kdp_pkg::DOT_PROD_W-1:0]       i_dot_hi,
    input  logic signed [q5kdp_pkg::CORR_PROD_W-1:0]      i_corr_lo,
    input  logic signed [q5kdp_pkg::CORR_PROD_W-1:0]      i_corr_hi,
    input  logic                                          i_out_ready,
    output logic                                          o_out_valid,
    output logic        [q5kdp_pkg::DOT_ACC_W-1:0]        o_dot_sum,
    output logic        [q5kdp_pkg::MIN_CORR_W-1:0]       o_min_corr
);
    import q5kdp_pkg::*;

    logic [DOT_ACC_W-1:0]  r_dot_acc;
    logic [CORR_ACC_W-1:0] r_corr_acc;
    logic [DOT_ACC_W-1:0]  n_dot_acc;
    logic [CORR_ACC_W-1:0] n_corr_acc;
    logic                  r_out_valid;
    logic [DOT_ACC_W-1:0]  r_dot_sum;
    logic [MIN_CORR_W-1:0] r_min_corr;

    assign n_dot_acc  = r_dot_acc + DOT_ACC_W'(i_dot_lo) + DOT_ACC_W'(i_dot_hi);
    assign n_corr_acc = r_corr_acc + CORR_ACC_W'(i_corr_lo) + CORR_ACC_W'(i_corr_hi);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dot_acc   <= '0;
            r_corr_acc  <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= (i_en && i_ctrl.valid && i_ctrl.last)
                           || (r_out_valid && !i_out_ready);
            if (i_en && i_ctrl.valid) begin
                if (i_ctrl.last) begin
                    r_dot_acc   <= '0;
                    r_corr_acc  <= '0;
                end else begin
                    r_dot_acc   <= n_dot_acc;
                    r_corr_acc  <= n_corr_acc;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en && i_ctrl.valid && i_ctrl.last) begin
            r_dot_sum  <= n_dot_acc;
            r_min_corr <= n_corr_acc[MIN_CORR_W-1:0];
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_dot_sum   = r_dot_sum;
    assign o_min_corr  = r_min_corr;

endmodule

@@ rtl/core/q5k_q8_integer_dot_product.sv @@
// Channel   Direction  Handshake                        Contents
// s_axis    in         s_axis_tvalid / s_axis_tready    scale word or data item
// m_axis    out        m_axis_tvalid / m_axis_tready    dot sum and min correction
//
// One transaction is taken per cycle unless a result waits in the output register;
// a result follows its last item through stage s1, stage s2 and the output register.
// Two lanes each multiply scale by weight, then by the activation, in two stages.
// Reset is synchronous and active low; the scale words are not cleared.
// While a result waits in the output register, the whole pipeline holds.
module q5k_q8_integer_dot_product (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  s_axis_tvalid,
    output logic                                  s_axis_tready,
    // word_index, scale_word, pair_index, low_bits_byte, high_bits_byte,
    // act_low, act_high, zero padding
    input  logic [q5kdp_pkg::S_TDATA_W-1:0]       s_axis_tdata,
    // action
    input  logic                                  s_axis_tuser,
    // last_item
    input  logic                                  s_axis_tlast,
    output logic                                  m_axis_tvalid,
    input  logic                                  m_axis_tready,
    // dot_sum, min_corr, zero padding
    output logic [q5kdp_pkg::M_TDATA_W-1:0]       m_axis_tdata
);
    import q5kdp_pkg::*;
    `include "assert_macros.svh"

    logic                       w_adv;
    logic                       w_accept;
    logic [1:0]                 w_word_index;
    logic [31:0]                w_scale_word;
    logic [1:0]                 w_pair;
    logic [7:0]                 w_low;
    logic [7:0]                 w_high;
    logic signed [ACT_W-1:0]    w_act_lo;
    logic signed [ACT_W-1:0]    w_act_hi;
    logic [2:0]                 w_sub_lo;
    logic [2:0]                 w_sub_hi;
    t_scale_min                 w_sm_lo;
    t_scale_min                 w_sm_hi;
    logic [WEIGHT_W-1:0]        w_wt_lo;
    logic [WEIGHT_W-1:0]        w_wt_hi;
    logic [31:0]                r_scale_words [SCALE_WORDS];
    t_ctrl                      r_s1;
    t_ctrl                      r_s2;
    t_ctrl                      n_s1;
    logic signed [DOT_PROD_W-1:0]  w_dot_lo;
    logic signed [DOT_PROD_W-1:0]  w_dot_hi;
    logic signed [CORR_PROD_W-1:0] w_corr_lo;
    logic signed [CORR_PROD_W-1:0] w_corr_hi;
    logic                       w_out_valid;
    logic [DOT_ACC_W-1:0]       w_dot_sum;
    logic [MIN_CORR_W-1:0]      w_min_corr;

    assign w_adv    = !w_out_valid || m_axis_tready;
    assign w_accept = s_axis_tvalid && w_adv;

    assign w_word_index = s_axis_tdata[1:0];
    assign w_scale_word = s_axis_tdata[33:2];
    assign w_pair       = s_axis_tdata[35:34];
    assign w_low        = s_axis_tdata[43:36];
    assign w_high       = s_axis_tdata[51:44];
    assign w_act_lo     = s_axis_tdata[59:52];
    assign w_act_hi     = s_axis_tdata[67:60];

    assign w_sub_lo = {w_pair, 1'b0};
    assign w_sub_hi = {w_pair, 1'b1};
    assign w_sm_lo  = unpack_scale_min(r_scale_words[0], r_scale_words[1],
                                       r_scale_words[2], w_sub_lo);
    assign w_sm_hi  = unpack_scale_min(r_scale_words[0], r_scale_words[1],
                                       r_scale_words[2], w_sub_hi);
    assign w_wt_lo  = {w_high[w_sub_lo], w_low[3:0]};
    assign w_wt_hi  = {w_high[w_sub_hi], w_low[7:4]};

    always_ff @(posedge i_clk) begin
        if (w_accept && t_action'(s_axis_tuser) == ACT_SCALE
                && 32'(w_word_index) < SCALE_WORDS) begin
            r_scale_words[w_word_index] <= w_scale_word;
        end
    end

    always_comb begin
        n_s1.valid = w_accept && t_action'(s_axis_tuser) == ACT_DATA;
        n_s1.last  = s_axis_tlast;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1 <= '0;
            r_s2 <= '0;
        end else if (w_adv) begin
            r_s1 <= n_s1;
            r_s2 <= r_s1;
        end
    end

    q5kdp_lane u_lane_lo (
        .i_clk       (i_clk),
        .i_en        (w_adv),
        .i_scale     (w_sm_lo.scale),
        .i_min       (w_sm_lo.min),
        .i_weight    (w_wt_lo),
        .i_act       (w_act_lo),
        .o_dot_prod  (w_dot_lo),
        .o_corr_prod (w_corr_lo)
    );

    q5kdp_lane u_lane_hi (
        .i_clk       (i_clk),
        .i_en        (w_adv),
        .i_scale     (w_sm_hi.scale),
        .i_min       (w_sm_hi.min),
        .i_weight    (w_wt_hi),
        .i_act       (w_act_hi),
        .o_dot_prod  (w_dot_hi),
        .o_corr_prod (w_corr_hi)
    );

    q5kdp_merge u_merge (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_en        (w_adv),
        .i_ctrl      (r_s2),
        .i_dot_lo    (w_dot_lo),
        .i_dot_hi    (w_dot_hi),
        .i_corr_lo   (w_corr_lo),
        .i_corr_hi   (w_corr_hi),
        .i_out_ready (m_axis_tready),
        .o_out_valid (w_out_valid),
        .o_dot_sum   (w_dot_sum),
        .o_min_corr  (w_min_corr)
    );

    assign s_axis_tready = w_adv;
    assign m_axis_tvalid = w_out_valid;
    assign m_axis_tdata  = {(M_TDATA_W - DOT_ACC_W - MIN_CORR_W)'(0), w_min_corr,
                            w_dot_sum};

    `ASSERT_IMPLY(a_stall_only_on_result, i_clk, i_rst_n,
                  !s_axis_tready, m_axis_tvalid,
                  "input stalled without a pending result")
    `ASSERT_IMPLY(a_result_from_last, i_clk, i_rst_n,
                  $rose(m_axis_tvalid), $past(r_s2.valid && r_s2.last),
                  "result without a final data item")
    `ASSERT_NEXT(a_stage_held, i_clk, i_rst_n,
                 r_s2.valid && !s_axis_tready, r_s2.valid,
                 "pending data item lost during a stall")

endmodule

@@ tb/tb_q5k_q8_integer_dot_product.sv @@
`timescale 1ns / 100ps

module tb_q5k_q8_integer_dot_product;

    import q5kdp_pkg::*;

    localparam int IDLE_LIMIT   = 4000;
    localparam int TAIL_CYCLES  = 20;
    localparam int TARGET_ITEMS = 1450;
    localparam int HOLD_CYCLES  = 400;
    localparam int HOLD_AT      = 400;

    typedef struct {
        t_action           action;
        logic [1:0]        word_index;
        logic [31:0]       scale_word;
        logic [1:0]        pair_index;
        logic [7:0]        low_bits;
        logic [7:0]        high_bits;
        logic signed [7:0] act_low;
        logic signed [7:0] act_high;
        logic              last_item;
    } t_q5_item;

    typedef struct {
        logic signed [DOT_ACC_W-1:0]  dot_sum;
        logic signed [MIN_CORR_W-1:0] min_corr;
    } t_block_sums;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 s_axis_tvalid = 1'b0;
    logic                 s_axis_tready;
    logic [S_TDATA_W-1:0] s_axis_tdata = '0;
    logic                 s_axis_tuser = 1'b0;
    logic                 s_axis_tlast = 1'b0;
    logic                 m_axis_tvalid;
    logic                 m_axis_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_axis_tdata;

    q5k_q8_integer_dot_product u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    t_q5_item    pending_items[$];
    t_block_sums awaited_sums[$];
    t_q5_item    offered_item;

    logic [31:0]           scale_regs[SCALE_WORDS];
    logic [DOT_ACC_W-1:0]  dot_acc_q = '0;
    logic [CORR_ACC_W-1:0] corr_acc_q = '0;

    int  stim_count = 0;
    int  in_count = 0;
    int  mismatches = 0;
    int  idle_cycles = 0;
    logic in_taken = 1'b0;

    int  burst_left = 1;
    int  gap_left = 0;
    int  rx_mode = 0;
    int  rx_mode_left = 0;
    int  rx_period = 1;
    int  rx_phase = 0;
    int  hold_left = 0;
    bit  hold_done = 1'b0;

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    function automatic t_q5_item random_item();
        t_q5_item it;
        it.action     = ACT_DATA;
        it.word_index = 2'($urandom_range(0, 3));
        it.scale_word = $urandom;
        it.pair_index = 2'($urandom_range(0, 3));
        it.low_bits   = 8'($urandom_range(0, 255));
        it.high_bits  = 8'($urandom_range(0, 255));
        it.act_low    = 8'($urandom_range(0, 255));
        it.act_high   = 8'($urandom_range(0, 255));
        it.last_item  = 1'($urandom_range(0, 1));
        return it;
    endfunction

    function automatic logic signed [7:0] rand_act();
        case ($urandom_range(0, 7))
            0: return -8'sd128;
            1: return 8'sd127;
            2: return 8'sd0;
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    function automatic logic [31:0] rand_scale_word();
        case ($urandom_range(0, 9))
            0: return 32'hFFFF_FFFF;
            1: return 32'h0000_0000;
            default: return $urandom;
        endcase
    endfunction

    function automatic void add_scale(int wi, logic [31:0] word, logic last_flag);
        t_q5_item it;
        it            = random_item();
        it.action     = ACT_SCALE;
        it.word_index = 2'(wi);
        it.scale_word = word;
        it.last_item  = last_flag;
        pending_items.push_back(it);
        if (wi != 3) begin
            stim_count++;
        end
    endfunction

    function automatic void add_data(int pair, logic [7:0] lo, logic [7:0] hi,
                                     logic signed [7:0] alo, logic signed [7:0] ahi,
                                     logic last_flag);
        t_q5_item it;
        it            = random_item();
        it.action     = ACT_DATA;
        it.pair_index = 2'(pair);
        it.low_bits   = lo;
        it.high_bits  = hi;
        it.act_low    = alo;
        it.act_high   = ahi;
        it.last_item  = last_flag;
        pending_items.push_back(it);
        stim_count++;
    endfunction

    function automatic void random_block(int n_items, bit reload);
        bit cyclic;
        cyclic = $urandom_range(0, 1);
        if (reload) begin
            for (int wi = 0; wi < SCALE_WORDS; wi++) begin
                add_scale(wi, rand_scale_word(), $urandom_range(0, 7) == 0);
            end
        end
        for (int i = 0; i < n_items; i++) begin
            add_data(cyclic ? (i % 4) : $urandom_range(0, 3),
                     8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                     rand_act(), rand_act(), i == n_items - 1);
        end
    endfunction

    function automatic void scale_of(input int sub, output logic [5:0] sc,
                                     output logic [5:0] mn);
        logic [7:0] b0;
        logic [7:0] b1;
        logic [7:0] b2;
        int k;
        k  = sub % 4;
        b0 = 8'(scale_regs[0] >> (8 * k));
        b1 = 8'(scale_regs[1] >> (8 * k));
        b2 = 8'(scale_regs[2] >> (8 * k));
        if (sub < 4) begin
            sc = b0[5:0];
            mn = b1[5:0];
        end else begin
            sc = {b0[7:6], b2[3:0]};
            mn = {b1[7:6], b2[7:4]};
        end
    endfunction

    function automatic void absorb_item(t_q5_item it);
        logic [5:0]  sc;
        logic [5:0]  mn;
        logic [3:0]  nib;
        int          sub;
        int          weight;
        int          act;
        t_block_sums sums;
        if (it.action == ACT_SCALE) begin
            if (it.word_index != 2'd3) begin
                scale_regs[it.word_index] = it.scale_word;
            end
            return;
        end
        for (int lane = 0; lane < 2; lane++) begin
            sub    = 2 * it.pair_index + lane;
            nib    = lane ? it.low_bits[7:4] : it.low_bits[3:0];
            weight = int'(nib) + (it.high_bits[sub] ? 16 : 0);
            act    = lane ? int'(it.act_high) : int'(it.act_low);
            scale_of(sub, sc, mn);
            dot_acc_q  = dot_acc_q + DOT_ACC_W'(int'(sc) * weight * act);
            corr_acc_q = corr_acc_q + CORR_ACC_W'(int'(mn) * act);
        end
        if (it.last_item) begin
            sums.dot_sum  = dot_acc_q;
            sums.min_corr = corr_acc_q[MIN_CORR_W-1:0];
            awaited_sums.push_back(sums);
            dot_acc_q  = '0;
            corr_acc_q = '0;
        end
    endfunction

    always @(posedge i_clk) begin
        logic signed [DOT_ACC_W-1:0]  got_dot;
        logic signed [MIN_CORR_W-1:0] got_corr;
        t_block_sums                  want;
        in_taken <= i_rst_n && s_axis_tvalid && s_axis_tready;
        if (i_rst_n) begin
            if (m_axis_tvalid && m_axis_tready) begin
                got_dot  = m_axis_tdata[DOT_ACC_W-1:0];
                got_corr = m_axis_tdata[DOT_ACC_W +: MIN_CORR_W];
                if (awaited_sums.size() == 0) begin
                    if (mismatches < 10) begin
                        $display("Unexpected result transaction: dot_sum %0d min_corr %0d",
                                 got_dot, got_corr);
                    end
                    mismatches++;
                end else begin
                    want = awaited_sums.pop_front();
                    if (got_dot !== want.dot_sum || got_corr !== want.min_corr) begin
                        if (mismatches < 10) begin
                            $display("Mismatch: dot_sum expected %0d got %0d, %s %0d got %0d",
                                     want.dot_sum, got_dot, "min_corr expected",
                                     want.min_corr, got_corr);
                        end
                        mismatches++;
                    end
                end
            end
            if (s_axis_tvalid && s_axis_tready) begin
                absorb_item(offered_item);
                in_count++;
            end
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
                idle_cycles = 0;
            end else begin
                idle_cycles++;
                if (idle_cycles >= IDLE_LIMIT) begin
                    $display("Timeout: no transaction for %0d cycles", IDLE_LIMIT);
                    $display("*** FAILED ***");
                    $finish;
                end
            end
        end
    end

    always @(negedge i_clk) begin
        if (i_rst_n && (!s_axis_tvalid || in_taken)) begin
            if (gap_left > 0) begin
                gap_left--;
                s_axis_tvalid <= 1'b0;
            end else if (pending_items.size() > 0) begin
                offered_item = pending_items.pop_front();
                s_axis_tvalid <= 1'b1;
                s_axis_tuser  <= offered_item.action;
                s_axis_tlast  <= offered_item.last_item;
                s_axis_tdata  <= {4'b0, offered_item.act_high, offered_item.act_low,
                                  offered_item.high_bits, offered_item.low_bits,
                                  offered_item.pair_index, offered_item.scale_word,
                                  offered_item.word_index};
                burst_left--;
                if (burst_left <= 0) begin
                    burst_left = $urandom_range(1, 40);
                    gap_left   = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 30)
                                                            : $urandom_range(0, 4);
                end
            end else begin
                s_axis_tvalid <= 1'b0;
            end
        end
    end

    always @(negedge i_clk) begin
        logic ready_next;
        ready_next = 1'b0;
        if (i_rst_n) begin
            if (!hold_done && in_count >= HOLD_AT) begin
                hold_done = 1'b1;
                hold_left = HOLD_CYCLES;
            end
            if (rx_mode_left <= 0) begin
                rx_mode      = $urandom_range(0, 3);
                rx_mode_left = $urandom_range(64, 256);
                rx_period    = $urandom_range(2, 6);
            end
            rx_mode_left--;
            rx_phase = (rx_phase + 1) % rx_period;
            if (hold_left > 0) begin
                hold_left--;
            end else begin
                case (rx_mode)
                    0: ready_next = 1'b1;
                    1: ready_next = $urandom_range(0, 9) < 7;
                    2: ready_next = $urandom_range(0, 9) < 3;
                    default: ready_next = rx_phase == 0;
                endcase
            end
        end
        m_axis_tready <= ready_next;
    end

    initial begin
        int pick;
        bit overlong_done;
        overlong_done = 1'b0;

        for (int wi = 0; wi < SCALE_WORDS; wi++) begin
            add_scale(wi, 32'hFFFF_FFFF, 1'b0);
        end
        add_scale(3, $urandom, 1'b1);
        add_scale(0, 32'hFFFF_FFFF, 1'b1);
        for (int p = 0; p < 4; p++) begin
            add_data(p, 8'hFF, 8'hFF, -8'sd128, -8'sd128, p == 3);
        end
        for (int p = 0; p < 4; p++) begin
            add_data(p, 8'hFF, 8'hFF, 8'sd127, 8'sd127, p == 3);
        end
        add_data(1, 8'h00, 8'h00, 8'sd127, -8'sd128, 1'b1);
        for (int wi = 0; wi < SCALE_WORDS; wi++) begin
            add_scale(wi, 32'h0000_0000, 1'b0);
        end
        add_data(0, 8'hFF, 8'hFF, -8'sd128, 8'sd127, 1'b1);
        add_scale(0, 32'h3F3F_3F3F, 1'b0);
        add_scale(1, 32'hC0C0_C0C0, 1'b0);
        add_scale(2, 32'hA5A5_A5A5, 1'b0);
        add_data(2, 8'h5A, 8'hAA, -8'sd128, 8'sd127, 1'b0);
        add_data(3, 8'hA5, 8'h55, 8'sd127, -8'sd128, 1'b1);

        while (stim_count < TARGET_ITEMS) begin
            if (!overlong_done && stim_count >= 700) begin
                overlong_done = 1'b1;
                for (int wi = 0; wi < SCALE_WORDS; wi++) begin
                    add_scale(wi, 32'hFFFF_FFFF, 1'b0);
                end
                for (int i = 0; i < 300; i++) begin
                    add_data(i % 4, 8'hFF, 8'hFF, -8'sd128, -8'sd128, i == 299);
                end
            end
            pick = $urandom_range(0, 99);
            if (pick < 70) begin
                case ($urandom_range(0, 19))
                    0: random_block(128, 1'b1);
                    1, 2: random_block($urandom_range(13, 40), 1'b1);
                    default: random_block($urandom_range(1, 12), 1'b1);
                endcase
            end else if (pick < 80) begin
                random_block($urandom_range(1, 12), 1'b0);
            end else if (pick < 90) begin
                if ($urandom_range(0, 1)) begin
                    add_scale(3, $urandom, 1'($urandom_range(0, 1)));
                end else begin
                    add_scale($urandom_range(0, 2), rand_scale_word(), 1'b1);
                end
            end else begin
                for (int j = $urandom_range(1, 2); j > 0; j--) begin
                    add_scale($urandom_range(0, 2), rand_scale_word(),
                              1'($urandom_range(0, 1)));
                end
                random_block($urandom_range(1, 10), 1'b0);
            end
        end

        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        while (pending_items.size() > 0 || s_axis_tvalid || awaited_sums.size() > 0) begin
            @(posedge i_clk);
        end
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (awaited_sums.size() > 0) begin
            mismatches++;
        end
        if (mismatches == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule

@@ q5k_q8_integer_dot_product.f @@
+incdir+rtl/core
rtl/core/q5kdp_pkg.sv
rtl/core/q5kdp_lane.sv
rtl/core/q5kdp_merge.sv
rtl/core/q5k_q8_integer_dot_product.sv
tb/tb_q5k_q8_integer_dot_product.sv
